### hdl/pbwt_pkg.sv
// Shared widths, operation codes, register indexes and the command and status
// structs of the positional BWT update unit.
// No dependencies; every other file imports this package.
`default_nettype none
package pbwt_pkg;

    localparam int NUM_HAPS  = 1024;
    localparam int SITE_BITS = 24;

    localparam int OP_W      = 2;
    localparam int INDEX_W   = 10;
    localparam int HAP_ID_W  = 10;
    localparam int DIV_W     = 24;
    localparam int BLOCK_W   = 11;
    localparam int ZCOUNT_W  = 11;
    localparam int SITE_W    = 24;
    localparam int NHAPS_W   = 11;
    localparam int MINLEN_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_HAPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;

    localparam logic [NHAPS_W-1:0]  NUM_HAPS_RESET   = 11'd1024;
    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 24'd1;

    // One command per datapath step, raised by the controller.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic q_start;
        logic adv_start;
        logic q_blk;
        logic p1_rd;
        logic p1_al;
        logic p1_wr;
        logic p2_rd;
        logic p2_wr;
        logic p3_rd;
        logic p3_wr;
        logic finish;
    } pbwt_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic p1_more;
        logic p2_more;
        logic p3_more;
        logic out_free;
    } pbwt_stat_t;

endpackage
`default_nettype wire

### hdl/pbwt_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on pbwt_pkg for the field widths.
`default_nettype none
interface pbwt_in_if;
    import pbwt_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic               allele;
    modport source (output valid, op, index, allele, input ready);
    modport sink   (input valid, op, index, allele, output ready);
endinterface

interface pbwt_out_if;
    import pbwt_pkg::*;
    logic                valid;
    logic                ready;
    logic [HAP_ID_W-1:0] hap_id;
    logic [DIV_W-1:0]    divergence;
    logic [BLOCK_W-1:0]  block_id;
    logic [ZCOUNT_W-1:0] zero_count;
    logic [SITE_W-1:0]   site_index;
    modport source (output valid, hap_id, divergence, block_id, zero_count, site_index,
                    input ready);
    modport sink   (input valid, hap_id, divergence, block_id, zero_count, site_index,
                    output ready);
endinterface
`default_nettype wire

### hdl/pbwt_ctrl.sv
// Controller state machine: sequences the clearing pass, loads, queries and the three
// passes of an advance. Depends on pbwt_pkg for the command and status structs.
`default_nettype none
module pbwt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [pbwt_pkg::OP_W-1:0] in_op,
    output logic                        in_ready,
    input  wire pbwt_pkg::pbwt_stat_t   stat,
    output pbwt_pkg::pbwt_cmd_t         cmd
);
    import pbwt_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_Q_BLK  = 12'b000000000100,
        ST_P1_RD  = 12'b000000001000,
        ST_P1_AL  = 12'b000000010000,
        ST_P1_WR  = 12'b000000100000,
        ST_P2_RD  = 12'b000001000000,
        ST_P2_WR  = 12'b000010000000,
        ST_P3_RD  = 12'b000100000000,
        ST_P3_WR  = 12'b001000000000,
        ST_FINISH = 12'b010000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.clr_step   = (state_reg == ST_CLEAR);
        cmd.load       = accept && (in_op == OP_LOAD);
        cmd.q_start    = accept && (in_op == OP_QUERY);
        cmd.adv_start  = accept && (in_op == OP_ADVANCE);
        cmd.q_blk      = (state_reg == ST_Q_BLK);
        cmd.p1_rd      = (state_reg == ST_P1_RD);
        cmd.p1_al      = (state_reg == ST_P1_AL);
        cmd.p1_wr      = (state_reg == ST_P1_WR);
        cmd.p2_rd      = (state_reg == ST_P2_RD);
        cmd.p2_wr      = (state_reg == ST_P2_WR);
        cmd.p3_rd      = (state_reg == ST_P3_RD);
        cmd.p3_wr      = (state_reg == ST_P3_WR);
        cmd.finish     = (state_reg == ST_FINISH);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (stat.clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (cmd.q_start)
                    state_next = ST_Q_BLK;
                else if (cmd.adv_start)
                    state_next = ST_P1_RD;
            end
            ST_Q_BLK:  state_next = ST_FINISH;
            ST_P1_RD:  state_next = stat.p1_more ? ST_P1_AL : ST_P2_RD;
            ST_P1_AL:  state_next = ST_P1_WR;
            ST_P1_WR:  state_next = ST_P1_RD;
            ST_P2_RD:  state_next = stat.p2_more ? ST_P2_WR : ST_P3_RD;
            ST_P2_WR:  state_next = ST_P2_RD;
            ST_P3_RD:  state_next = stat.p3_more ? ST_P3_WR : ST_FINISH;
            ST_P3_WR:  state_next = ST_P3_RD;
            ST_FINISH: if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### hdl/pbwt_dp.sv
// Datapath: configuration registers, the haplotype memories, the running
// divergences, counters and the result register.
// Depends on pbwt_pkg; driven by commands from pbwt_ctrl.
`default_nettype none
module pbwt_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pbwt_pkg::pbwt_cmd_t           cmd,
    output pbwt_pkg::pbwt_stat_t               stat,
    input  wire logic [pbwt_pkg::INDEX_W-1:0]  index,
    input  wire logic                          allele,
    input  wire logic                          cfg_we,
    input  wire logic [pbwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbwt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [pbwt_pkg::HAP_ID_W-1:0]      hap_id,
    output logic [pbwt_pkg::DIV_W-1:0]         divergence,
    output logic [pbwt_pkg::BLOCK_W-1:0]       block_id,
    output logic [pbwt_pkg::ZCOUNT_W-1:0]      zero_count,
    output logic [pbwt_pkg::SITE_W-1:0]        site_index
);
    import pbwt_pkg::*;

    localparam int HW = $clog2(NUM_HAPS);
    localparam int CW = $clog2(NUM_HAPS + 1);
    localparam int SW = SITE_BITS;
    localparam int LW = ((SW > MINLEN_W) ? SW : MINLEN_W) + 1;
    localparam logic [SW-1:0] SITE_MAX = {SW{1'b1}};

    // Memories, each with one write and one registered read port.
    logic [HW-1:0] pre_mem  [NUM_HAPS];
    logic [SW-1:0] div_mem  [NUM_HAPS];
    logic [CW-1:0] blk_mem  [NUM_HAPS];
    logic          al_mem   [NUM_HAPS];
    logic [HW-1:0] oid_mem  [NUM_HAPS];
    logic [SW-1:0] odiv_mem [NUM_HAPS];

    logic [HW-1:0] pre_rd, oid_rd;
    logic [SW-1:0] div_rd, odiv_rd;
    logic [CW-1:0] blk_rd;
    logic          al_rd;

    logic          pre_we, pre_re, blk_we, al_we, oid_we, oid_re;
    logic [HW-1:0] pre_wa, pre_ra, blk_wa, idx_addr;
    logic [HW-1:0] pre_wd;
    logic [SW-1:0] div_wd;
    logic [CW-1:0] blk_wd;

    logic [NHAPS_W-1:0]  num_haps_reg;
    logic [MINLEN_W-1:0] min_length_reg;
    logic [CW-1:0]       i_reg, zeros_reg, ones_reg, id_reg;
    logic [CW-1:0]       i_next, zeros_next, ones_next, id_next, id_inc;
    logic [SW-1:0]       site_reg, site_next, site_sat;
    logic [SW-1:0]       pz_reg, po_reg, pz_next, po_next, nz, no;
    logic                adv_reg, q_oob_reg, out_valid_reg;
    logic [CW-1:0]       m;
    logic                idx_ok, new_block;
    logic [CW-1:0]       cat_addr;

    logic [HAP_ID_W-1:0] hap_id_reg;
    logic [DIV_W-1:0]    divergence_reg;
    logic [BLOCK_W-1:0]  block_id_reg;
    logic [ZCOUNT_W-1:0] zero_count_reg;
    logic [SITE_W-1:0]   site_index_reg;

    assign idx_ok   = (32'(index) < NUM_HAPS);
    assign idx_addr = HW'(index);
    assign m        = (32'(num_haps_reg) > NUM_HAPS) ? CW'(NUM_HAPS) : CW'(num_haps_reg);
    assign site_sat = (site_reg == SITE_MAX) ? site_reg : site_reg + 1'b1;
    assign nz       = (div_rd > pz_reg) ? div_rd : pz_reg;
    assign no       = (div_rd > po_reg) ? div_rd : po_reg;
    assign cat_addr = zeros_reg + i_reg;
    assign new_block = (LW'(div_rd) + LW'(min_length_reg)) > LW'(site_reg);
    assign id_inc   = new_block ? id_reg + 1'b1 : id_reg;

    always_comb
    begin
        stat.clr_last = (i_reg == CW'(NUM_HAPS - 1));
        stat.p1_more  = (i_reg < m);
        stat.p2_more  = (i_reg < ones_reg);
        stat.p3_more  = (i_reg < m);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Memory port steering.
    always_comb
    begin
        pre_we = cmd.clr_step || (cmd.p1_wr && !al_rd) || cmd.p2_wr;
        pre_wa = cmd.clr_step ? i_reg[HW-1:0] :
                 cmd.p1_wr    ? zeros_reg[HW-1:0] : cat_addr[HW-1:0];
        pre_wd = cmd.clr_step ? i_reg[HW-1:0] : cmd.p1_wr ? pre_rd : oid_rd;
        div_wd = cmd.clr_step ? '0 : cmd.p1_wr ? nz : odiv_rd;
        pre_re = cmd.q_start || (cmd.p1_rd && stat.p1_more) || (cmd.p3_rd && stat.p3_more);
        pre_ra = cmd.q_start ? idx_addr : i_reg[HW-1:0];
        blk_we = cmd.clr_step || cmd.p3_wr;
        blk_wa = cmd.clr_step ? i_reg[HW-1:0] : pre_rd;
        blk_wd = cmd.clr_step ? '0 : id_inc;
        al_we  = cmd.load && idx_ok;
        oid_we = cmd.p1_wr && al_rd;
        oid_re = cmd.p2_rd && stat.p2_more;
    end

    always_ff @(posedge clk)
    begin
        if (pre_we)
            pre_mem[pre_wa] <= pre_wd;
        if (pre_re)
            pre_rd <= pre_mem[pre_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pre_we)
            div_mem[pre_wa] <= div_wd;
        if (pre_re)
            div_rd <= div_mem[pre_ra];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
            blk_mem[blk_wa] <= blk_wd;
        if (cmd.q_blk)
            blk_rd <= blk_mem[pre_rd];
    end

    always_ff @(posedge clk)
    begin
        if (al_we)
            al_mem[idx_addr] <= allele;
        if (cmd.p1_al)
            al_rd <= al_mem[pre_rd];
    end

    always_ff @(posedge clk)
    begin
        if (oid_we)
            oid_mem[ones_reg[HW-1:0]] <= pre_rd;
        if (oid_re)
            oid_rd <= oid_mem[i_reg[HW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (oid_we)
            odiv_mem[ones_reg[HW-1:0]] <= no;
        if (oid_re)
            odiv_rd <= odiv_mem[i_reg[HW-1:0]];
    end

    // Counters and running divergences.
    always_comb
    begin
        i_next     = i_reg;
        zeros_next = zeros_reg;
        ones_next  = ones_reg;
        id_next    = id_reg;
        site_next  = site_reg;
        pz_next    = pz_reg;
        po_next    = po_reg;
        if (cmd.clr_step)
            i_next = i_reg + 1'b1;
        if (cmd.adv_start)
        begin
            i_next     = '0;
            zeros_next = '0;
            ones_next  = '0;
            id_next    = '0;
            pz_next    = site_sat;
            po_next    = site_sat;
        end
        if (cmd.p1_rd && !stat.p1_more)
            i_next = '0;
        if (cmd.p1_wr)
        begin
            i_next = i_reg + 1'b1;
            if (!al_rd)
            begin
                zeros_next = zeros_reg + 1'b1;
                pz_next    = '0;
                po_next    = no;
            end
            else
            begin
                ones_next = ones_reg + 1'b1;
                po_next   = '0;
                pz_next   = nz;
            end
        end
        // The ones have been copied back: the site is now complete.
        if (cmd.p2_rd && !stat.p2_more)
        begin
            i_next    = '0;
            site_next = site_sat;
        end
        if (cmd.p2_wr)
            i_next = i_reg + 1'b1;
        if (cmd.p3_wr)
        begin
            i_next  = i_reg + 1'b1;
            id_next = id_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            zeros_reg      <= '0;
            ones_reg       <= '0;
            id_reg         <= '0;
            site_reg       <= '0;
            adv_reg        <= 1'b0;
            q_oob_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            num_haps_reg   <= NUM_HAPS_RESET;
            min_length_reg <= MIN_LENGTH_RESET;
        end
        else
        begin
            i_reg     <= i_next;
            zeros_reg <= zeros_next;
            ones_reg  <= ones_next;
            id_reg    <= id_next;
            site_reg  <= site_next;
            if (cmd.q_start || cmd.adv_start)
                adv_reg <= cmd.adv_start;
            if (cmd.q_start)
                q_oob_reg <= !idx_ok;
            if (cmd.finish && stat.out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && (cfg_index == REG_NUM_HAPS))
                num_haps_reg <= cfg_data[NHAPS_W-1:0];
            if (cfg_we && (cfg_index == REG_MIN_LENGTH))
                min_length_reg <= cfg_data[MINLEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pz_reg <= pz_next;
        po_reg <= po_next;
        if (cmd.finish && stat.out_free)
        begin
            if (adv_reg)
            begin
                hap_id_reg     <= '0;
                divergence_reg <= '0;
                block_id_reg   <= '0;
                zero_count_reg <= ZCOUNT_W'(zeros_reg);
                site_index_reg <= SITE_W'(site_reg);
            end
            else
            begin
                hap_id_reg     <= q_oob_reg ? '0 : HAP_ID_W'(pre_rd);
                divergence_reg <= q_oob_reg ? '0 : DIV_W'(div_rd);
                block_id_reg   <= q_oob_reg ? '0 : BLOCK_W'(blk_rd);
                zero_count_reg <= '0;
                site_index_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign hap_id     = hap_id_reg;
    assign divergence = divergence_reg;
    assign block_id   = block_id_reg;
    assign zero_count = zero_count_reg;
    assign site_index = site_index_reg;

endmodule
`default_nettype wire

### hdl/pbwt_prefix_divergence_update_unit.sv
// A load writes the allele memory and presents no result; a query reads the prefix and
// divergence memories, then the block memory. An advance over m haplotypes presents its
// result after three passes through the prefix and divergence memories.
// One item is in work at a time. After reset a clearing pass fills the prefix,
// divergence and block memories; no input is taken until it ends.
`default_nettype none
module pbwt_prefix_divergence_update_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pbwt_in_if.sink                              in_item,
    pbwt_out_if.source                           out_item,
    input  wire logic                            cfg_we,
    input  wire logic [pbwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbwt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pbwt_pkg::*;

    pbwt_cmd_t  cmd;
    pbwt_stat_t stat;

    pbwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_op    (in_item.op),
        .in_ready (in_item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbwt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .index      (in_item.index),
        .allele     (in_item.allele),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (out_item.ready),
        .out_valid  (out_item.valid),
        .hap_id     (out_item.hap_id),
        .divergence (out_item.divergence),
        .block_id   (out_item.block_id),
        .zero_count (out_item.zero_count),
        .site_index (out_item.site_index)
    );

endmodule
`default_nettype wire
